### design/dpp_pkg.sv
// ----------------------------------------------------------------------------
// dpp_pkg
// shared constants, register map and configuration type of the depth
// pixel to point converter
// ----------------------------------------------------------------------------
package dpp_pkg;

    localparam int DEPTH_BITS_DEF = 24;
    localparam int MAX_DIM_DEF    = 4096;

    // register widths
    localparam int NEAR_W = 20;
    localparam int FAR_W  = 24;
    localparam int CLIP_W = 24;
    localparam int DIM_W  = 13;
    localparam int PIX_W  = 12;
    localparam int NF_W   = NEAR_W + FAR_W;

    // depth quotient bits (clip range is below 2^24, one spare bit)
    localparam int ZQ_W   = CLIP_W + 1;
    // coordinate quotient bits before saturation
    localparam int XQ_W   = 32;
    localparam int OUT_W  = 32;

    localparam int FIFO_DEPTH = 4;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // register indexes
    localparam logic [2:0] REG_NEAR   = 3'd0;
    localparam logic [2:0] REG_FAR    = 3'd1;
    localparam logic [2:0] REG_CLIP   = 3'd2;
    localparam logic [2:0] REG_WIDTH  = 3'd3;
    localparam logic [2:0] REG_HEIGHT = 3'd4;
    localparam logic [2:0] REG_FRAME  = 3'd5;

    typedef struct packed {
        logic [NEAR_W-1:0] near_plane;
        logic [FAR_W-1:0]  far_plane;
        logic [CLIP_W-1:0] clip_range;
        logic [DIM_W-1:0]  image_width;
        logic [DIM_W-1:0]  image_height;
        logic              body_frame;
    } t_cfg;

    // magnitude bits of a pixel offset 2u-w for a given largest dimension
    function automatic int offm_w(input int max_dim);
        int d;
        d = $clog2(max_dim + 1);
        return (d > DIM_W) ? d : DIM_W;
    endfunction

    // bits of one classified item between front and back
    function automatic int item_w(input int depth_bits, input int max_dim);
        return 2 + NF_W + (FAR_W + depth_bits + 1) + (depth_bits + NEAR_W)
            + 2 * (offm_w(max_dim) + 2) + offm_w(max_dim);
    endfunction

endpackage

### design/dpp_pdiv.sv
// ----------------------------------------------------------------------------
// dpp_pdiv
// pipelined restoring divider, one quotient bit per stage, with a sideband
// that travels alongside the operands
// ----------------------------------------------------------------------------
module dpp_pdiv #(
    parameter int DW = 8,
    parameter int QW = 8,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [DW-1:0] i_rem,
    input  logic [QW-1:0] i_bits,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [QW-1:0] o_quo,
    output logic [DW-1:0] o_rem,
    output logic [DW-1:0] o_den,
    output logic [SW-1:0] o_side
);

    logic [DW-1:0] r_rem  [QW];
    logic [QW-1:0] r_bits [QW];
    logic [QW-1:0] r_q    [QW];
    logic [DW-1:0] r_den  [QW];
    logic [SW-1:0] r_side [QW];
    logic [QW-1:0] r_vld;

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [DW-1:0] rem_in, den_in, n_rem;
        logic [QW-1:0] bits_in, q_in, n_q;
        logic [SW-1:0] side_in;
        logic          v_in, ge;
        logic [DW:0]   r2, diff;

        if (k == 0) begin : g_first
            assign rem_in  = i_rem;
            assign den_in  = i_den;
            assign bits_in = i_bits;
            assign q_in    = '0;
            assign side_in = i_side;
            assign v_in    = i_valid;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign den_in  = r_den[k-1];
            assign bits_in = r_bits[k-1];
            assign q_in    = r_q[k-1];
            assign side_in = r_side[k-1];
            assign v_in    = r_vld[k-1];
        end

        always_comb begin
            r2    = {rem_in, bits_in[QW-1-k]};
            diff  = r2 - {1'b0, den_in};
            ge    = (r2 >= {1'b0, den_in});
            n_rem = ge ? diff[DW-1:0] : r2[DW-1:0];
            n_q   = q_in;
            n_q[QW-1-k] = ge;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_bits[k] <= bits_in;
                r_q[k]    <= n_q;
                r_den[k]  <= den_in;
                r_side[k] <= side_in;
            end
        end
    end

    assign o_valid = r_vld[QW-1];
    assign o_quo   = r_q[QW-1];
    assign o_rem   = r_rem[QW-1];
    assign o_den   = r_den[QW-1];
    assign o_side  = r_side[QW-1];

endmodule

### design/dpp_fifo.sv
// ----------------------------------------------------------------------------
// dpp_fifo
// short show-ahead queue between the front and the back
// ----------------------------------------------------------------------------
module dpp_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = dpp_pkg::FIFO_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic         o_full,
    output logic         o_nempty,
    output logic [W-1:0] o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full   = (r_cnt == CW'(DEPTH));
    assign o_nempty = (r_cnt != '0);
    assign o_data   = r_mem[r_rp];
    assign do_push  = i_push && !o_full;
    assign do_pop   = i_pop && o_nempty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

### design/dpp_front.sv
// ----------------------------------------------------------------------------
// dpp_front
// accepts pixels, flags invalid codes and forms the products and offsets
// that the back needs
// ----------------------------------------------------------------------------
module dpp_front #(
    parameter int DEPTH_BITS = dpp_pkg::DEPTH_BITS_DEF,
    parameter int MAX_DIM    = dpp_pkg::MAX_DIM_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  dpp_pkg::t_cfg         i_cfg,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [DEPTH_BITS-1:0] i_depth_code,
    input  logic [dpp_pkg::PIX_W-1:0] i_column,
    input  logic [dpp_pkg::PIX_W-1:0] i_row,
    input  logic                  i_frame_end,
    input  logic                  i_full,
    output logic                  o_push,
    output logic [dpp_pkg::item_w(DEPTH_BITS, MAX_DIM)-1:0] o_item
);
    import dpp_pkg::*;

    localparam int OFFM_W = offm_w(MAX_DIM);
    localparam int OFF_W  = OFFM_W + 2;
    localparam int P1_W   = FAR_W + DEPTH_BITS + 1;
    localparam int P2_W   = DEPTH_BITS + NEAR_W;
    localparam int ITEM_W = item_w(DEPTH_BITS, MAX_DIM);

    logic [OFFM_W-1:0]   w_ext, h_ext, w_c, h_c;
    logic [DEPTH_BITS:0] inv;
    logic [NF_W-1:0]     n_nf;
    logic [P1_W-1:0]     n_p1;
    logic [P2_W-1:0]     n_p2;
    logic [OFF_W-1:0]    n_off_x, n_off_y;
    logic                r_valid;
    logic [ITEM_W-1:0]   r_item;

    always_comb begin
        w_ext = OFFM_W'(i_cfg.image_width);
        h_ext = OFFM_W'(i_cfg.image_height);
        w_c   = (w_ext > OFFM_W'(MAX_DIM)) ? OFFM_W'(MAX_DIM) : w_ext;
        h_c   = (h_ext > OFFM_W'(MAX_DIM)) ? OFFM_W'(MAX_DIM) : h_ext;
        if (h_c == '0) begin
            h_c = OFFM_W'(1);
        end
        inv     = {1'b1, {DEPTH_BITS{1'b0}}} - {1'b0, i_depth_code};
        n_nf    = NF_W'(i_cfg.near_plane) * NF_W'(i_cfg.far_plane);
        n_p1    = P1_W'(i_cfg.far_plane) * P1_W'(inv);
        n_p2    = P2_W'(i_depth_code) * P2_W'(i_cfg.near_plane);
        n_off_x = OFF_W'({i_column, 1'b0}) - OFF_W'(w_c);
        n_off_y = OFF_W'({i_row, 1'b0}) - OFF_W'(h_c);
    end

    assign o_ready = !r_valid || !i_full;
    assign o_push  = r_valid && !i_full;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= {(i_depth_code != '0), i_frame_end, n_nf, n_p1, n_p2,
                       n_off_x, n_off_y, h_c};
        end
    end

endmodule

### design/dpp_back.sv
// ----------------------------------------------------------------------------
// dpp_back
// linearises depth, scales the pixel offsets, saturates and picks the
// output frame
// ----------------------------------------------------------------------------
module dpp_back #(
    parameter int DEPTH_BITS = dpp_pkg::DEPTH_BITS_DEF,
    parameter int MAX_DIM    = dpp_pkg::MAX_DIM_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  dpp_pkg::t_cfg         i_cfg,
    input  logic                  i_valid,
    input  logic [dpp_pkg::item_w(DEPTH_BITS, MAX_DIM)-1:0] i_item,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_keep,
    output logic [dpp_pkg::OUT_W-1:0] o_point_x,
    output logic [dpp_pkg::OUT_W-1:0] o_point_y,
    output logic [dpp_pkg::OUT_W-1:0] o_point_z,
    output logic                  o_frame_done
);
    import dpp_pkg::*;

    localparam int OFFM_W = offm_w(MAX_DIM);
    localparam int OFF_W  = OFFM_W + 2;
    localparam int P1_W   = FAR_W + DEPTH_BITS + 1;
    localparam int P2_W   = DEPTH_BITS + NEAR_W;
    localparam int DEN_W  = FAR_W + DEPTH_BITS;
    localparam int N_W    = NF_W + DEPTH_BITS;
    localparam int SZ_W   = DEN_W + 3 + 2 * OFF_W + OFFM_W;
    localparam int MAG_W  = OFFM_W + CLIP_W;
    localparam int A_W    = MAG_W + 2;
    localparam int DV_W   = OFFM_W + 1;
    localparam int SX_W   = 4 + CLIP_W;
    localparam int SV_W   = XQ_W + 2;

    logic en;

    // unpack
    logic              u_nz, u_fe;
    logic [NF_W-1:0]   u_nf;
    logic [P1_W-1:0]   u_p1;
    logic [P2_W-1:0]   u_p2;
    logic [OFF_W-1:0]  u_offx, u_offy;
    logic [OFFM_W-1:0] u_h;

    assign {u_nz, u_fe, u_nf, u_p1, u_p2, u_offx, u_offy, u_h} = i_item;

    assign en    = !o_valid || i_ready;
    assign o_pop = en && i_valid;

    // stage 1: denominator
    logic              r1_v, r1_nz, r1_fe;
    logic [NF_W-1:0]   r1_nf;
    logic [DEN_W-1:0]  r1_den;
    logic [OFF_W-1:0]  r1_offx, r1_offy;
    logic [OFFM_W-1:0] r1_h;

    // stage 2: quotient range check
    logic              r2_v, r2_ovf;
    logic [DEN_W-1:0]  r2_rem0, r2_den;
    logic [ZQ_W-1:0]   r2_low;
    logic [SZ_W-DEN_W-1:0] r2_side;

    logic [N_W-1:0]    num;
    logic [DEN_W-1:0]  top_ext;
    logic              n2_ovf;

    always_comb begin
        num     = {r1_nf, {DEPTH_BITS{1'b0}}};
        top_ext = DEN_W'(num[N_W-1:ZQ_W]);
        n2_ovf  = (top_ext >= r1_den);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_nz   <= u_nz;
            r1_fe   <= u_fe;
            r1_nf   <= u_nf;
            r1_den  <= DEN_W'(P1_W'(u_p1) + P1_W'(u_p2));
            r1_offx <= u_offx;
            r1_offy <= u_offy;
            r1_h    <= u_h;
            r2_ovf  <= n2_ovf;
            r2_rem0 <= n2_ovf ? '0 : top_ext;
            r2_den  <= r1_den;
            r2_low  <= num[ZQ_W-1:0];
            r2_side <= {(r1_den == '0), r1_nz, r1_fe, r1_offx, r1_offy, r1_h};
        end
    end

    // depth division
    logic              zd_v;
    logic [ZQ_W-1:0]   zd_q;
    logic [DEN_W-1:0]  zd_rem, zd_den;
    logic [SZ_W-DEN_W-1:0] zd_side;
    logic              zd_ovf;

    dpp_pdiv #(
        .DW (DEN_W),
        .QW (ZQ_W),
        .SW (SZ_W - DEN_W + 1)
    ) u_zdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r2_v),
        .i_rem   (r2_rem0),
        .i_bits  (r2_low),
        .i_den   (r2_den),
        .i_side  ({r2_ovf, r2_side}),
        .o_valid (zd_v),
        .o_quo   (zd_q),
        .o_rem   (zd_rem),
        .o_den   (zd_den),
        .o_side  ({zd_ovf, zd_side})
    );

    // stage 3: rounding, clip test, offset magnitudes
    logic              z_den0, z_nz, z_fe;
    logic [OFF_W-1:0]  z_offx, z_offy;
    logic [OFFM_W-1:0] z_h;
    logic              rbit, n3_keep;
    logic [ZQ_W:0]     zq;
    logic [OFF_W-1:0]  nx, ny;

    assign {z_den0, z_nz, z_fe, z_offx, z_offy, z_h} = zd_side;

    always_comb begin
        rbit    = ({zd_rem, 1'b0} >= {1'b0, zd_den});
        zq      = {1'b0, zd_q} + (ZQ_W + 1)'(rbit);
        n3_keep = z_nz && (z_den0 || (!zd_ovf && (zq <= (ZQ_W + 1)'(i_cfg.clip_range))));
        nx      = z_offx[OFF_W-1] ? (~z_offx + 1'b1) : z_offx;
        ny      = z_offy[OFF_W-1] ? (~z_offy + 1'b1) : z_offy;
    end

    logic              r3_v, r3_keep, r3_fe, r3_sx, r3_sy;
    logic [CLIP_W-1:0] r3_z;
    logic [OFFM_W-1:0] r3_mx, r3_my, r3_h;

    // stage 4: offset times depth
    logic              r4_v, r4_keep, r4_fe, r4_sx, r4_sy;
    logic [CLIP_W-1:0] r4_z;
    logic [MAG_W-1:0]  r4_mx, r4_my;
    logic [OFFM_W-1:0] r4_h;

    // stage 5: range check of the scaled offsets
    logic [A_W-1:0]    ax, ay;
    logic [DV_W-1:0]   dv, tx, ty;
    logic              n5_ox, n5_oy;

    always_comb begin
        ax    = {1'b0, r4_mx, 1'b0} + A_W'(r4_h);
        ay    = {1'b0, r4_my, 1'b0} + A_W'(r4_h);
        dv    = {r4_h, 1'b0};
        tx    = DV_W'(ax[A_W-1:XQ_W]);
        ty    = DV_W'(ay[A_W-1:XQ_W]);
        n5_ox = (tx >= dv);
        n5_oy = (ty >= dv);
    end

    logic              r5_v;
    logic [DV_W-1:0]   r5_rx, r5_ry, r5_dv;
    logic [XQ_W-1:0]   r5_lx, r5_ly;
    logic [SX_W-1:0]   r5_sx;
    logic [1:0]        r5_sy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else if (en) begin
            r3_v <= zd_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_keep <= n3_keep;
            r3_fe   <= z_fe;
            r3_z    <= z_den0 ? '0 : zq[CLIP_W-1:0];
            r3_sx   <= z_offx[OFF_W-1];
            r3_sy   <= z_offy[OFF_W-1];
            r3_mx   <= nx[OFFM_W-1:0];
            r3_my   <= ny[OFFM_W-1:0];
            r3_h    <= z_h;

            r4_keep <= r3_keep;
            r4_fe   <= r3_fe;
            r4_z    <= r3_z;
            r4_sx   <= r3_sx;
            r4_sy   <= r3_sy;
            r4_mx   <= MAG_W'(r3_mx) * MAG_W'(r3_z);
            r4_my   <= MAG_W'(r3_my) * MAG_W'(r3_z);
            r4_h    <= r3_h;

            r5_rx   <= n5_ox ? '0 : tx;
            r5_ry   <= n5_oy ? '0 : ty;
            r5_dv   <= dv;
            r5_lx   <= ax[XQ_W-1:0];
            r5_ly   <= ay[XQ_W-1:0];
            r5_sx   <= {r4_keep, r4_fe, r4_sx, n5_ox, r4_z};
            r5_sy   <= {r4_sy, n5_oy};
        end
    end

    // coordinate divisions
    logic              xd_v, yd_v;
    logic [XQ_W-1:0]   xd_q, yd_q;
    logic [DV_W-1:0]   xd_rem, yd_rem, xd_den, yd_den;
    logic [SX_W-1:0]   xd_side;
    logic [1:0]        yd_side;

    dpp_pdiv #(
        .DW (DV_W),
        .QW (XQ_W),
        .SW (SX_W)
    ) u_xdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r5_v),
        .i_rem   (r5_rx),
        .i_bits  (r5_lx),
        .i_den   (r5_dv),
        .i_side  (r5_sx),
        .o_valid (xd_v),
        .o_quo   (xd_q),
        .o_rem   (xd_rem),
        .o_den   (xd_den),
        .o_side  (xd_side)
    );

    dpp_pdiv #(
        .DW (DV_W),
        .QW (XQ_W),
        .SW (2)
    ) u_ydiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r5_v),
        .i_rem   (r5_ry),
        .i_bits  (r5_ly),
        .i_den   (r5_dv),
        .i_side  (r5_sy),
        .o_valid (yd_v),
        .o_quo   (yd_q),
        .o_rem   (yd_rem),
        .o_den   (yd_den),
        .o_side  (yd_side)
    );

    // output stage: sign, frame, saturation
    function automatic logic [OUT_W-1:0] sat32(input logic [SV_W-1:0] v);
        logic signed [SV_W-1:0] s;
        s = signed'(v);
        if (s > signed'(SV_W'({1'b0, {(OUT_W - 1){1'b1}}}))) begin
            return {1'b0, {(OUT_W - 1){1'b1}}};
        end else if (s < -signed'(SV_W'({1'b1, {(OUT_W - 1){1'b0}}}))) begin
            return {1'b1, {(OUT_W - 1){1'b0}}};
        end
        return v[OUT_W-1:0];
    endfunction

    logic              o_k, o_fe, o_sx, o_ox, o_sy, o_oy;
    logic [CLIP_W-1:0] o_z;
    logic [SV_W-1:0]   mx, my, vx, vy, vz, nx_o, ny_o, nz_o;
    logic              r_o_valid, r_keep, r_fe;
    logic [OUT_W-1:0]  r_px, r_py, r_pz;
    logic              unused_ok;

    assign {o_k, o_fe, o_sx, o_ox, o_z} = xd_side;
    assign {o_sy, o_oy} = yd_side;
    // remainders and divisors of the coordinate units are not needed
    assign unused_ok = yd_v ^ (^xd_rem) ^ (^yd_rem) ^ (^xd_den) ^ (^yd_den);

    always_comb begin
        mx = o_ox ? {2'b01, {XQ_W{1'b0}}} : SV_W'(xd_q);
        my = o_oy ? {2'b01, {XQ_W{1'b0}}} : SV_W'(yd_q);
        vx = o_sx ? (~mx + 1'b1) : mx;
        vy = o_sy ? (~my + 1'b1) : my;
        vz = SV_W'(o_z);
        if (i_cfg.body_frame) begin
            nx_o = vz;
            ny_o = ~vx + 1'b1;
            nz_o = ~vy + 1'b1;
        end else begin
            nx_o = vx;
            ny_o = vy;
            nz_o = vz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_o_valid <= xd_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_keep <= o_k;
            r_fe   <= o_fe;
            r_px   <= o_k ? sat32(nx_o) : '0;
            r_py   <= o_k ? sat32(ny_o) : '0;
            r_pz   <= (o_k && !unused_ok) || (o_k && unused_ok) ? sat32(nz_o) : '0;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_keep       = r_keep;
    assign o_point_x    = r_px;
    assign o_point_y    = r_py;
    assign o_point_z    = r_pz;
    assign o_frame_done = r_fe;

endmodule

### design/depth_pixel_to_point.sv
// ----------------------------------------------------------------------------
// depth_pixel_to_point
// turns depth-buffer pixels into 3d points in the camera or body frame
// ----------------------------------------------------------------------------
// One pixel is taken per clock unless the queue is full, and one point comes
// out for every pixel, in order. From acceptance to its result a pixel passes
// the front register, the queue, the denominator and quotient range check
// stages, a 25-stage pipelined divider for the linear depth, stages of
// rounding, scaling and range checks, two parallel 32-stage dividers for
// the image plane offsets and the output register. An output stall freezes
// the back pipeline, and the four-entry queue lets the front keep accepting
// until it fills. Registers sit on an APB port at byte address 4*index.
module depth_pixel_to_point #(
    parameter int DEPTH_BITS = dpp_pkg::DEPTH_BITS_DEF,
    parameter int MAX_DIM    = dpp_pkg::MAX_DIM_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dpp_pkg::ADDR_W-1:0]  paddr,
    input  logic [dpp_pkg::DATA_W-1:0]  pwdata,
    output logic [dpp_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [DEPTH_BITS-1:0]       i_depth_code,
    input  logic [dpp_pkg::PIX_W-1:0]   i_column,
    input  logic [dpp_pkg::PIX_W-1:0]   i_row,
    input  logic                        i_frame_end,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_keep,
    output logic [dpp_pkg::OUT_W-1:0]   o_point_x,
    output logic [dpp_pkg::OUT_W-1:0]   o_point_y,
    output logic [dpp_pkg::OUT_W-1:0]   o_point_z,
    output logic                        o_frame_done
);
    import dpp_pkg::*;

    localparam int ITEM_W = item_w(DEPTH_BITS, MAX_DIM);

    t_cfg        r_cfg;
    logic        wr;
    logic [2:0]  idx;

    assign pready = 1'b1;
    assign idx    = paddr[4:2];
    assign wr     = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.near_plane   <= NEAR_W'(41);
            r_cfg.far_plane    <= FAR_W'(1024000);
            r_cfg.clip_range   <= CLIP_W'(30720);
            r_cfg.image_width  <= DIM_W'(640);
            r_cfg.image_height <= DIM_W'(480);
            r_cfg.body_frame   <= 1'b1;
        end else if (wr) begin
            unique case (idx)
                REG_NEAR:   r_cfg.near_plane   <= pwdata[NEAR_W-1:0];
                REG_FAR:    r_cfg.far_plane    <= pwdata[FAR_W-1:0];
                REG_CLIP:   r_cfg.clip_range   <= pwdata[CLIP_W-1:0];
                REG_WIDTH:  r_cfg.image_width  <= pwdata[DIM_W-1:0];
                REG_HEIGHT: r_cfg.image_height <= pwdata[DIM_W-1:0];
                REG_FRAME:  r_cfg.body_frame   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_NEAR:   prdata = DATA_W'(r_cfg.near_plane);
            REG_FAR:    prdata = DATA_W'(r_cfg.far_plane);
            REG_CLIP:   prdata = DATA_W'(r_cfg.clip_range);
            REG_WIDTH:  prdata = DATA_W'(r_cfg.image_width);
            REG_HEIGHT: prdata = DATA_W'(r_cfg.image_height);
            REG_FRAME:  prdata = DATA_W'(r_cfg.body_frame);
            default:    prdata = '0;
        endcase
    end

    logic              f_push, q_full, q_nempty, q_pop;
    logic [ITEM_W-1:0] f_item, q_item;

    dpp_front #(
        .DEPTH_BITS (DEPTH_BITS),
        .MAX_DIM    (MAX_DIM)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_depth_code (i_depth_code),
        .i_column     (i_column),
        .i_row        (i_row),
        .i_frame_end  (i_frame_end),
        .i_full       (q_full),
        .o_push       (f_push),
        .o_item       (f_item)
    );

    dpp_fifo #(
        .W     (ITEM_W),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (f_push),
        .i_data   (f_item),
        .i_pop    (q_pop),
        .o_full   (q_full),
        .o_nempty (q_nempty),
        .o_data   (q_item)
    );

    dpp_back #(
        .DEPTH_BITS (DEPTH_BITS),
        .MAX_DIM    (MAX_DIM)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (q_nempty),
        .i_item       (q_item),
        .o_pop        (q_pop),
        .o_valid      (o_out_valid),
        .i_ready      (i_out_ready),
        .o_keep       (o_keep),
        .o_point_x    (o_point_x),
        .o_point_y    (o_point_y),
        .o_point_z    (o_point_z),
        .o_frame_done (o_frame_done)
    );

endmodule
